// File: hw/rtl/grse_pkg.sv
// shared types and constants for the grey run stripe extractor
package grse_pkg;

  localparam int MAX_PAYLOAD_DEF = 4096;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic KIND_STRIPE = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam logic [1:0] END_NO_ROOM   = 2'd0;
  localparam logic [1:0] END_BACKWARDS = 2'd1;
  localparam logic [1:0] END_UNTERM    = 2'd2;
  localparam logic [1:0] END_SHORT     = 2'd3;

  localparam logic [7:0] HI_COL8  = 8'h01;
  localparam logic [7:0] HI_COL9  = 8'h02;
  localparam logic [7:0] HI_LINE8 = 8'h04;

  localparam int MIN_PAYLOAD = 4;
  localparam int HEADER_ROOM = 4;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_COL  = 5'b00010,
    PH_LINE = 5'b00100,
    PH_HIGH = 5'b01000,
    PH_RUN  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         end_reason;
    logic [8:0]         line;
    logic [9:0]         column_start;
    logic signed [13:0] column_stop;
    logic [11:0]        points;
    logic [19:0]        weight_sum;
    logic [30:0]        moment_sum;
    logic               last;
  } res_t;

endpackage

// File: hw/rtl/grey_run_stripe_extractor.sv
// grey run stripe extractor: parses greyscale payload bytes into stripe results
// output: each result is written into a registered result queue before it can be taken
// throughput: one input word per cycle while ready is high; a word that causes
//   two results puts both into the result queue, and ready drops while the
//   result queue holds more than two entries
// reset: phase goes idle, counters, sums and the result queue are cleared
module grey_run_stripe_extractor
  import grse_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [12:0]        payload_length,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [1:0]         end_reason,
  output logic [8:0]         line,
  output logic [9:0]         column_start,
  output logic signed [13:0] column_stop,
  output logic [11:0]        points,
  output logic [19:0]        weight_sum,
  output logic [30:0]        moment_sum,
  output logic               last
);

  localparam int LW = $clog2(MAX_PAYLOAD + 1);

  phase_t        phase, phase_next;
  logic [LW-1:0] byte_position, byte_position_next;
  logic [LW-1:0] length_in_use, length_in_use_next;
  logic [9:0]    start_column, start_column_next;
  logic [8:0]    stripe_line, stripe_line_next;
  logic [8:0]    previous_line, previous_line_next;
  logic [12:0]   run_index, run_index_next;
  logic [19:0]   run_sum, run_sum_next;
  logic [31:0]   run_moment, run_moment_next;

  res_t          queue [4];
  logic [1:0]    wr_ptr, rd_ptr;
  logic [2:0]    count;

  logic          in_acc, out_acc;
  logic          push0, push1;
  res_t          res0, res1;
  logic [LW-1:0] len_sat;
  logic [LW-1:0] pos_inc;
  logic [LW:0]   pos_room;
  logic [9:0]    col_full;
  logic [8:0]    line_full;
  logic [12:0]   pts;
  logic [20:0]   prod;
  res_t          stripe, end_res;

  assign in_ready  = (count <= 3'd2);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = (count != 3'd0);
  assign out_acc   = out_valid & out_ready;

  always_comb begin
    if ({19'd0, payload_length} > 32'(MAX_PAYLOAD)) begin
      len_sat = LW'(MAX_PAYLOAD);
    end else begin
      len_sat = LW'(payload_length);
    end
  end

  assign pos_inc   = byte_position + LW'(1);
  assign pos_room  = {1'b0, pos_inc} + (LW + 1)'(HEADER_ROOM);
  assign col_full  = {data_byte[1] & HI_COL9[1], data_byte[0] & HI_COL8[0],
                      start_column[7:0]};
  assign line_full = {data_byte[2] & HI_LINE8[2], stripe_line[7:0]};
  assign pts       = run_index - 13'd1;
  assign prod      = run_index * data_byte;

  always_comb begin
    stripe              = '0;
    stripe.kind         = KIND_STRIPE;
    stripe.end_reason   = END_NO_ROOM;
    stripe.line         = stripe_line;
    stripe.column_start = start_column;
    stripe.column_stop  = {4'd0, start_column} + {1'b0, pts} - 14'sd1;
    stripe.points       = pts[11:0];
    stripe.weight_sum   = run_sum;
    stripe.moment_sum   = run_moment[30:0];
    stripe.last         = 1'b1;
    end_res             = '0;
    end_res.kind        = KIND_END;
    end_res.last        = 1'b1;
  end

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    length_in_use_next = length_in_use;
    start_column_next  = start_column;
    stripe_line_next   = stripe_line;
    previous_line_next = previous_line;
    run_index_next     = run_index;
    run_sum_next       = run_sum;
    run_moment_next    = run_moment;
    push0              = 1'b0;
    push1              = 1'b0;
    res0               = end_res;
    res1               = end_res;
    if (in_acc) begin
      if (op == OP_START) begin
        length_in_use_next = len_sat;
        byte_position_next = '0;
        previous_line_next = '0;
        run_index_next     = '0;
        run_sum_next       = '0;
        run_moment_next    = '0;
        if (len_sat < LW'(MIN_PAYLOAD)) begin
          push0           = 1'b1;
          res0.end_reason = END_SHORT;
          phase_next      = PH_IDLE;
        end else if (len_sat == LW'(MIN_PAYLOAD)) begin
          push0           = 1'b1;
          res0.end_reason = END_NO_ROOM;
          phase_next      = PH_IDLE;
        end else begin
          phase_next = PH_COL;
        end
      end else if (phase != PH_IDLE && byte_position < length_in_use) begin
        byte_position_next = pos_inc;
        case (phase)
          PH_COL: begin
            start_column_next = {2'd0, data_byte};
            phase_next        = PH_LINE;
          end
          PH_LINE: begin
            stripe_line_next = {1'b0, data_byte};
            phase_next       = PH_HIGH;
          end
          PH_HIGH: begin
            start_column_next = col_full;
            stripe_line_next  = line_full;
            if (line_full < previous_line) begin
              push0           = 1'b1;
              res0.end_reason = END_BACKWARDS;
              phase_next      = PH_IDLE;
            end else begin
              previous_line_next = line_full;
              run_index_next     = 13'd1;
              run_sum_next       = '0;
              run_moment_next    = '0;
              phase_next         = PH_RUN;
            end
          end
          PH_RUN: begin
            if (data_byte != 8'd0) begin
              run_sum_next    = run_sum + {12'd0, data_byte};
              run_moment_next = run_moment + {11'd0, prod};
              run_index_next  = run_index + 13'd1;
              if (pos_inc >= length_in_use) begin
                push0           = 1'b1;
                res0.end_reason = END_UNTERM;
                phase_next      = PH_IDLE;
              end
            end else begin
              push0 = 1'b1;
              res0  = stripe;
              if (pos_room < {1'b0, length_in_use}) begin
                phase_next = PH_COL;
              end else begin
                res0.last       = 1'b0;
                push1           = 1'b1;
                res1.end_reason = END_NO_ROOM;
                phase_next      = PH_IDLE;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      length_in_use <= '0;
      start_column  <= '0;
      stripe_line   <= '0;
      previous_line <= '0;
      run_index     <= '0;
      run_sum       <= '0;
      run_moment    <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      length_in_use <= length_in_use_next;
      start_column  <= start_column_next;
      stripe_line   <= stripe_line_next;
      previous_line <= previous_line_next;
      run_index     <= run_index_next;
      run_sum       <= run_sum_next;
      run_moment    <= run_moment_next;
      wr_ptr        <= wr_ptr + {1'b0, push0} + {1'b0, push1};
      rd_ptr        <= rd_ptr + {1'b0, out_acc};
      count         <= count + {2'd0, push0} + {2'd0, push1} - {2'd0, out_acc};
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (push0) begin
      queue[wr_ptr] <= res0;
    end
    if (push1) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

  assign kind         = queue[rd_ptr].kind;
  assign end_reason   = queue[rd_ptr].end_reason;
  assign line         = queue[rd_ptr].line;
  assign column_start = queue[rd_ptr].column_start;
  assign column_stop  = queue[rd_ptr].column_stop;
  assign points       = queue[rd_ptr].points;
  assign weight_sum   = queue[rd_ptr].weight_sum;
  assign moment_sum   = queue[rd_ptr].moment_sum;
  assign last         = queue[rd_ptr].last;

endmodule
